// ----- hdl/range_id_allocator_core_macros.svh -----
// assertion macros shared by the allocator rtl
`ifndef RANGE_ID_ALLOCATOR_CORE_MACROS_SVH
`define RANGE_ID_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// plain property under a synchronous active low reset
`define RIA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("allocator check failed");
// overlapping implication
`define RIA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("allocator check failed");
`else
`define RIA_ASSERT(lbl, clk, rstn, prop)
`define RIA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hdl/ria_pkg.sv -----
// types, constants and codes of the range id allocator
package ria_pkg;

  localparam int MAX_RANGES = 32;
  localparam int ID_BITS    = 16;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int HW_W       = ID_BITS + 1;
  localparam int END_W      = ID_BITS + 2;
  localparam int LEN_W      = 17;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_NOP     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXHAUST = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [15:0]      start_id;
    logic [LEN_W-1:0] run_length;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]      first_id;
    logic [1:0]       status;
    logic [LEN_W-1:0] min_free_id;
  } out_beat_t;

  typedef struct packed {
    logic [ID_BITS-1:0] lo;
    logic [HW_W-1:0]    hi;
  } range_t;

  typedef enum logic [2:0] {
    C_NOP, C_SHUP, C_SHDN, C_SETLO, C_SETHI, C_ADDLO, C_MERGE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   idx;
    logic [ID_BITS-1:0] lo;
    logic [HW_W-1:0]    hi;
  } cell_cmd_t;

  typedef struct packed {
    logic [ID_BITS-1:0] start;
    logic [END_W-1:0]   stop;
    logic [LEN_W-1:0]   count;
    logic [LEN_W-1:0]   lim;
  } req_ctx_t;

  typedef struct packed {
    logic fit;
    logic exact;
    logic ovl;
    logic gt;
    logic hi_eq;
    logic lo_eq;
  } cell_flags_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_ACT, S_TRIM, S_DONE
  } fsm_t;

endpackage

// ----- hdl/ria_cell.sv -----
// one free-range cell of the shifting range table
module ria_cell (
  input  logic                          clk,
  input  logic [ria_pkg::IDX_W-1:0]     cell_idx,
  input  ria_pkg::cell_cmd_t            cmd,
  input  ria_pkg::req_ctx_t             ctx,
  input  ria_pkg::range_t               prev_rng,
  input  ria_pkg::range_t               next_rng,
  output ria_pkg::range_t               rng,
  output ria_pkg::cell_flags_t          flags
);

  ria_pkg::range_t rng_r, rng_nxt;
  logic [ria_pkg::END_W-1:0] span;
  logic [ria_pkg::END_W-1:0] lo_plus;

  assign rng     = rng_r;
  assign span    = ria_pkg::END_W'(rng_r.hi) - ria_pkg::END_W'(rng_r.lo);
  assign lo_plus = ria_pkg::END_W'(rng_r.lo) + ria_pkg::END_W'(ctx.count);

  always_comb begin
    flags.fit   = (span >= ria_pkg::END_W'(ctx.count)) &&
                  (lo_plus <= ria_pkg::END_W'(ctx.lim));
    flags.exact = (span == ria_pkg::END_W'(ctx.count));
    flags.ovl   = (ria_pkg::END_W'(ctx.start) < ria_pkg::END_W'(rng_r.hi)) &&
                  (ria_pkg::END_W'(rng_r.lo) < ctx.stop);
    flags.gt    = (rng_r.lo > ctx.start);
    flags.hi_eq = (rng_r.hi == ria_pkg::HW_W'(ctx.start));
    flags.lo_eq = (ria_pkg::END_W'(rng_r.lo) == ctx.stop);
  end

  always_comb begin
    rng_nxt = rng_r;
    unique case (cmd.op)
      ria_pkg::C_SHUP: begin
        if (cell_idx > cmd.idx) rng_nxt = prev_rng;
        else if (cell_idx == cmd.idx) begin
          rng_nxt.lo = cmd.lo;
          rng_nxt.hi = cmd.hi;
        end
      end
      ria_pkg::C_SHDN: begin
        if (cell_idx >= cmd.idx) rng_nxt = next_rng;
      end
      ria_pkg::C_SETLO: begin
        if (cell_idx == cmd.idx) rng_nxt.lo = cmd.lo;
      end
      ria_pkg::C_SETHI: begin
        if (cell_idx == cmd.idx) rng_nxt.hi = cmd.hi;
      end
      ria_pkg::C_ADDLO: begin
        if (cell_idx == cmd.idx) rng_nxt.lo = lo_plus[ria_pkg::ID_BITS-1:0];
      end
      ria_pkg::C_MERGE: begin
        // absorb the upper neighbour's top, close the gap above
        if (cell_idx == cmd.idx) rng_nxt.hi = next_rng.hi;
        else if (cell_idx > cmd.idx) rng_nxt = next_rng;
      end
      default: rng_nxt = rng_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rng_r <= rng_nxt;
  end

endmodule

// ----- hdl/range_id_allocator_core.sv -----
// top level of the first-fit range id allocator with coalescing
//
//  channel | direction | handshake           | beat
//  in_     | in        | in_valid / in_stall | ria_pkg::in_beat_t
//  out_    | out       | out_valid/out_stall | ria_pkg::out_beat_t
//  cfg_    | in        | cfg_valid/cfg_ready | id_limit, 17 bits
//
// after the accepting edge a request passes the evaluate, act, trim and done states before out_valid rises
// each free range absorbed into the mark repeats the trim state, until no live range ends at the mark
// the row of cells compares all ranges in parallel in the evaluate state, the shift or
// update follows in the act state, and no new request is taken until the block is back in idle
// rst_n is synchronous; it empties the table, zeroes the mark and sets the limit
// the next request is taken while the previous result still waits in the
// output register; a stalled result holds the next request in its done state
`include "range_id_allocator_core_macros.svh"
module range_id_allocator_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ria_pkg::in_beat_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ria_pkg::out_beat_t    out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ria_pkg::LEN_W-1:0] cfg_data
);

  localparam int N = ria_pkg::MAX_RANGES;

  // control state
  ria_pkg::fsm_t                 state_r, state_nxt;
  logic [ria_pkg::CNT_W-1:0]     used_r, used_nxt;
  logic [ria_pkg::HW_W-1:0]      hw_r, hw_nxt;
  logic [ria_pkg::LEN_W-1:0]     limit_r;
  logic                          out_valid_r, out_valid_nxt;

  // request and result payload
  ria_pkg::in_beat_t             req_r;
  ria_pkg::out_beat_t            out_data_r;
  logic [15:0]                   first_r, first_nxt;
  logic [1:0]                    status_r, status_nxt;

  // registered cell compare results, already masked by liveness
  logic [N-1:0] fit_r, exact_r, ovl_r, gt_r, hieq_r, loeq_r;

  ria_pkg::range_t      rng [N];
  ria_pkg::cell_flags_t flg [N];
  ria_pkg::cell_cmd_t   cmd;
  ria_pkg::req_ctx_t    ctx;
  logic [N-1:0]         live;

  // row of cells, each linked to both neighbours
  for (genvar g = 0; g < N; g++) begin : g_cell
    ria_pkg::range_t prev_rng, next_rng;
    if (g == 0) begin : g_first
      assign prev_rng = '0;
    end else begin : g_prev
      assign prev_rng = rng[g-1];
    end
    if (g == N - 1) begin : g_last
      assign next_rng = '0;
    end else begin : g_next
      assign next_rng = rng[g+1];
    end
    assign live[g] = (ria_pkg::CNT_W'(g) < used_r);
    ria_cell u_cell (
      .clk      (clk),
      .cell_idx (ria_pkg::IDX_W'(g)),
      .cmd      (cmd),
      .ctx      (ctx),
      .prev_rng (prev_rng),
      .next_rng (next_rng),
      .rng      (rng[g]),
      .flags    (flg[g])
    );
  end

  // limits above the id space act as the whole space
  always_comb begin
    ctx.start = req_r.start_id;
    ctx.count = req_r.run_length;
    ctx.stop  = ria_pkg::END_W'(req_r.start_id) + ria_pkg::END_W'(req_r.run_length);
    ctx.lim   = (limit_r > ria_pkg::LEN_W'(1 << ria_pkg::ID_BITS)) ?
                ria_pkg::LEN_W'(1 << ria_pkg::ID_BITS) : limit_r;
  end

  // first fitting range and insertion point
  logic                      fit_any, ovl_any;
  logic [ria_pkg::IDX_W-1:0] fit_idx;
  logic [ria_pkg::CNT_W-1:0] pos;
  logic [ria_pkg::IDX_W-1:0] pos_i, pos_m1;
  logic                      left_ok, right_ok;

  always_comb begin
    fit_idx = '0;
    pos     = used_r;
    for (int i = N - 1; i >= 0; i--) begin
      if (fit_r[i]) fit_idx = ria_pkg::IDX_W'(i);
      if (gt_r[i])  pos     = ria_pkg::CNT_W'(i);
    end
  end

  assign fit_any  = |fit_r;
  assign ovl_any  = |ovl_r;
  assign pos_i    = pos[ria_pkg::IDX_W-1:0];
  assign pos_m1   = ria_pkg::IDX_W'(pos - ria_pkg::CNT_W'(1));
  assign left_ok  = (pos != '0) && hieq_r[pos_m1];
  assign right_ok = (pos < used_r) && loeq_r[pos_i];

  // top live range for the trim step
  ria_pkg::range_t           top_rng;
  logic                      trim_hit;
  assign top_rng  = rng[ria_pkg::IDX_W'(used_r - ria_pkg::CNT_W'(1))];
  assign trim_hit = (used_r != '0) && (top_rng.hi == hw_r);

  logic                      out_load;
  assign out_load  = (state_r == ria_pkg::S_DONE) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != ria_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ria_pkg::S_IDLE: if (in_valid) state_nxt = ria_pkg::S_EVAL;
      ria_pkg::S_EVAL: state_nxt = ria_pkg::S_ACT;
      ria_pkg::S_ACT:  state_nxt = ria_pkg::S_TRIM;
      ria_pkg::S_TRIM: if (!trim_hit) state_nxt = ria_pkg::S_DONE;
      ria_pkg::S_DONE: if (out_load) state_nxt = ria_pkg::S_IDLE;
      default:         state_nxt = ria_pkg::S_IDLE;
    endcase
  end

  // datapath decisions
  logic [ria_pkg::END_W-1:0] hw_plus;
  assign hw_plus = ria_pkg::END_W'(hw_r) + ria_pkg::END_W'(req_r.run_length);

  always_comb begin
    cmd        = '{op: ria_pkg::C_NOP, idx: '0, lo: '0, hi: '0};
    hw_nxt     = hw_r;
    used_nxt   = used_r;
    first_nxt  = first_r;
    status_nxt = status_r;
    unique case (state_r)
      ria_pkg::S_ACT: begin
        first_nxt  = '0;
        status_nxt = ria_pkg::ST_OK;
        unique case (req_r.kind)
          ria_pkg::KIND_ALLOC: begin
            if (req_r.run_length == '0) begin
              status_nxt = ria_pkg::ST_BAD;
            end else if (fit_any) begin
              first_nxt = rng[fit_idx].lo;
              cmd.idx   = fit_idx;
              if (exact_r[fit_idx]) begin
                cmd.op   = ria_pkg::C_SHDN;
                used_nxt = used_r - ria_pkg::CNT_W'(1);
              end else begin
                cmd.op = ria_pkg::C_ADDLO;
              end
            end else if (hw_plus > ria_pkg::END_W'(ctx.lim)) begin
              status_nxt = ria_pkg::ST_EXHAUST;
            end else begin
              first_nxt = hw_r[15:0];
              hw_nxt    = hw_plus[ria_pkg::HW_W-1:0];
            end
          end
          ria_pkg::KIND_RELEASE: begin
            if (req_r.run_length == '0 || ctx.stop > ria_pkg::END_W'(hw_r) || ovl_any) begin
              status_nxt = ria_pkg::ST_BAD;
            end else if (ctx.stop == ria_pkg::END_W'(hw_r)) begin
              hw_nxt = ria_pkg::HW_W'(req_r.start_id);
            end else if (left_ok && right_ok) begin
              cmd.op   = ria_pkg::C_MERGE;
              cmd.idx  = pos_m1;
              used_nxt = used_r - ria_pkg::CNT_W'(1);
            end else if (left_ok) begin
              cmd.op  = ria_pkg::C_SETHI;
              cmd.idx = pos_m1;
              cmd.hi  = ctx.stop[ria_pkg::HW_W-1:0];
            end else if (right_ok) begin
              cmd.op  = ria_pkg::C_SETLO;
              cmd.idx = pos_i;
              cmd.lo  = req_r.start_id;
            end else if (used_r == ria_pkg::CNT_W'(N)) begin
              status_nxt = ria_pkg::ST_FULL;
            end else begin
              cmd.op   = ria_pkg::C_SHUP;
              cmd.idx  = pos_i;
              cmd.lo   = req_r.start_id;
              cmd.hi   = ctx.stop[ria_pkg::HW_W-1:0];
              used_nxt = used_r + ria_pkg::CNT_W'(1);
            end
          end
          ria_pkg::KIND_CLEAR: begin
            used_nxt = '0;
            hw_nxt   = '0;
          end
          default: ;
        endcase
      end
      ria_pkg::S_TRIM: begin
        // a free range ending at the mark is absorbed into it
        if (trim_hit) begin
          hw_nxt   = ria_pkg::HW_W'(top_rng.lo);
          used_nxt = used_r - ria_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ria_pkg::S_IDLE;
      used_r      <= '0;
      hw_r        <= '0;
      limit_r     <= ria_pkg::LEN_W'(65536);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      hw_r        <= hw_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    status_r <= status_nxt;
    if (state_r == ria_pkg::S_IDLE && in_valid) req_r <= in_data;
    if (state_r == ria_pkg::S_EVAL) begin
      for (int i = 0; i < N; i++) begin
        fit_r[i]   <= live[i] && flg[i].fit;
        exact_r[i] <= live[i] && flg[i].exact;
        ovl_r[i]   <= live[i] && flg[i].ovl;
        gt_r[i]    <= live[i] && flg[i].gt;
        hieq_r[i]  <= live[i] && flg[i].hi_eq;
        loeq_r[i]  <= live[i] && flg[i].lo_eq;
      end
    end
    if (out_load) begin
      out_data_r.first_id    <= first_r;
      out_data_r.status      <= status_r;
      out_data_r.min_free_id <= (used_r != '0) ? ria_pkg::LEN_W'(rng[0].lo) : hw_r;
    end
  end

  `RIA_ASSERT(a_used_bound, clk, rst_n, used_r <= ria_pkg::CNT_W'(N))
  `RIA_ASSERT(a_mark_bound, clk, rst_n, hw_r <= ria_pkg::HW_W'(1 << ria_pkg::ID_BITS))
  `RIA_ASSERT_IMP(a_accept_eval, clk, rst_n, in_valid && !in_stall, ##1 state_r == ria_pkg::S_EVAL)
  `RIA_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == ria_pkg::S_DONE)

endmodule
